### sv/miq_pkg.sv
// ----------------------------------------------------------------------------
// miq_pkg : shared types and constants for the middle insert queue
// Command and status codes, controller state, control struct, result record.
// ----------------------------------------------------------------------------
package miq_pkg;

    localparam int unsigned CAPACITY_DEF = 256;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 9;

    // command codes (the unused code is decoded as a pop)
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MIDDLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // result buffer occupancy seen by the controller
    typedef enum logic [1:0] {
        S_EMPTY,
        S_ONE,
        S_TWO
    } t_ctrl_state;

    // controller to datapath commands
    typedef struct packed {
        logic exec;           // commit the accepted command to the queue
        logic load_main;      // new result into the output register
        logic load_skid;      // new result into the skid register
        logic main_from_skid; // skid register moves to the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0]         entry_count;
        logic [STATUS_W-1:0]        status;
        logic                       popped_valid;
        logic signed [VALUE_W-1:0]  popped_value;
    } t_result;

endpackage

### sv/miq_ctrl.sv
// ----------------------------------------------------------------------------
// miq_ctrl : handshake controller
// Tracks how many results are buffered and steers the datapath registers.
// ----------------------------------------------------------------------------
module miq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output miq_pkg::t_ctrl_cmd  o_cmd
);

    miq_pkg::t_ctrl_state r_state;
    miq_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= miq_pkg::S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            miq_pkg::S_EMPTY: begin
                if (i_in_valid) begin
                    n_state = miq_pkg::S_ONE;
                end
            end
            miq_pkg::S_ONE: begin
                if (i_in_valid && !i_out_ready) begin
                    n_state = miq_pkg::S_TWO;
                end else if (!i_in_valid && i_out_ready) begin
                    n_state = miq_pkg::S_EMPTY;
                end
            end
            miq_pkg::S_TWO: begin
                if (i_out_ready) begin
                    n_state = miq_pkg::S_ONE;
                end
            end
            default: begin
                n_state = miq_pkg::S_EMPTY;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready           = 1'b0;
        o_out_valid          = 1'b0;
        o_cmd.exec           = 1'b0;
        o_cmd.load_main      = 1'b0;
        o_cmd.load_skid      = 1'b0;
        o_cmd.main_from_skid = 1'b0;
        case (r_state)
            miq_pkg::S_EMPTY: begin
                o_in_ready      = 1'b1;
                o_cmd.exec      = i_in_valid;
                o_cmd.load_main = i_in_valid;
            end
            miq_pkg::S_ONE: begin
                o_in_ready      = 1'b1;
                o_out_valid     = 1'b1;
                o_cmd.exec      = i_in_valid;
                o_cmd.load_main = i_in_valid && i_out_ready;
                o_cmd.load_skid = i_in_valid && !i_out_ready;
            end
            miq_pkg::S_TWO: begin
                o_out_valid          = 1'b1;
                o_cmd.main_from_skid = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/miq_datapath.sv
// ----------------------------------------------------------------------------
// miq_datapath : cell chain, occupancy counter and result registers
// Each cell picks hold, load, shift from its lower or its upper neighbour.
// ----------------------------------------------------------------------------
module miq_datapath #(
    parameter int unsigned CAPACITY = miq_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  miq_pkg::t_ctrl_cmd                    i_cmd,
    input  logic [miq_pkg::CMD_W-1:0]             i_op,
    input  logic signed [miq_pkg::VALUE_W-1:0]    i_value,
    output miq_pkg::t_result                      o_result
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic signed [miq_pkg::VALUE_W-1:0] r_cell [CAPACITY];
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;
    miq_pkg::t_result                   r_main;
    miq_pkg::t_result                   r_skid;
    miq_pkg::t_result                   w_res;

    logic             w_is_insert;
    logic             w_full;
    logic             w_empty;
    logic             w_do_insert;
    logic             w_do_pop;
    logic [CNT_W:0]   w_half_sum;
    logic [CNT_W-1:0] w_pos;
    logic [31:0]      w_count_ext;

    always_comb begin
        case (i_op)
            miq_pkg::CMD_PUSH:   w_is_insert = 1'b1;
            miq_pkg::CMD_MIDDLE: w_is_insert = 1'b1;
            miq_pkg::CMD_POP:    w_is_insert = 1'b0;
            default:             w_is_insert = 1'b0;
        endcase
    end

    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_do_insert = w_is_insert && !w_full;
    assign w_do_pop    = !w_is_insert && !w_empty;

    // middle slot keeps (count+1)/2 entries ahead
    assign w_half_sum = {1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1};
    assign w_pos      = (i_op == miq_pkg::CMD_PUSH) ? r_count : w_half_sum[CNT_W:1];

    always_comb begin
        n_count = r_count;
        if (w_do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_count_ext = 32'(n_count);

    always_comb begin
        w_res.popped_value = '0;
        w_res.popped_valid = 1'b0;
        w_res.status       = miq_pkg::ST_OK;
        w_res.entry_count  = w_count_ext[miq_pkg::COUNT_W-1:0];
        if (w_is_insert && w_full) begin
            w_res.status = miq_pkg::ST_FULL;
        end else if (!w_is_insert && w_empty) begin
            w_res.status = miq_pkg::ST_EMPTY;
        end else if (w_do_pop) begin
            w_res.popped_value = r_cell[0];
            w_res.popped_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // cell chain, no reset: cells at or beyond the count are never read
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [miq_pkg::VALUE_W-1:0] w_lower;
        logic signed [miq_pkg::VALUE_W-1:0] w_upper;
        logic                               w_shift_up;
        logic                               w_shift_down;

        if (g == 0) begin : g_first
            assign w_lower    = r_cell[g];
            assign w_shift_up = 1'b0;
        end else begin : g_mid
            assign w_lower    = r_cell[g-1];
            assign w_shift_up = (CNT_W'(g) > w_pos) && (CNT_W'(g) <= r_count);
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_upper      = r_cell[g];
            assign w_shift_down = 1'b0;
        end else begin : g_body
            assign w_upper      = r_cell[g+1];
            assign w_shift_down = (CNT_W'(g + 1) < r_count);
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec && w_do_insert) begin
                if (CNT_W'(g) == w_pos) begin
                    r_cell[g] <= i_value;
                end else if (w_shift_up) begin
                    r_cell[g] <= w_lower;
                end
            end else if (i_cmd.exec && w_do_pop && w_shift_down) begin
                r_cell[g] <= w_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_main) begin
            r_main <= w_res;
        end else if (i_cmd.main_from_skid) begin
            r_main <= r_skid;
        end
        if (i_cmd.load_skid) begin
            r_skid <= w_res;
        end
    end

    assign o_result = r_main;

endmodule

### sv/middle_insert_queue_unit.sv
// A result is registered at its transfer, in the skid register while one is stalled.
// Throughput: one command per cycle while the result buffer has room.
// A two-deep result buffer keeps input transfers going while one result waits.
// Reset (synchronous, active low) empties the queue and the result buffer;
// cell contents are left undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// middle_insert_queue_unit : bounded queue with tail push, middle insert, pop
// Controller and cell-chain datapath behind stream interfaces.
// ----------------------------------------------------------------------------
module middle_insert_queue_unit #(
    parameter int unsigned CAPACITY = miq_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] popped_value, [40:32] entry_count
    output logic [2:0]  o_m_axis_tuser    // [0] popped_valid, [2:1] status
);

    miq_pkg::t_ctrl_cmd w_cmd;
    miq_pkg::t_result   w_result;

    // controller owns the handshake and the result buffer state
    miq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // datapath holds the entries, the count and the buffered results
    miq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_op     (i_s_axis_tuser),
        .i_value  (i_s_axis_tdata),
        .o_result (w_result)
    );

    // pack the result; top bits of tdata pad to a whole byte
    assign o_m_axis_tdata = {7'd0, w_result.entry_count, w_result.popped_value};
    assign o_m_axis_tuser = {w_result.status, w_result.popped_valid};

`ifndef ASSERT_OFF
    // at most one result buffer steering command in any cycle
    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_main, w_cmd.load_skid, w_cmd.main_from_skid}))
        else $error("result buffer steering conflict");

    // skid only fills while the held result is stalled
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_skid |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("skid loaded without a stalled result");

    // a popped entry always carries an ok status
    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tuser[2:1] == miq_pkg::ST_OK))
        else $error("popped entry with error status");

    // every transfer in is committed to the queue
    a_exec_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec == (i_s_axis_tvalid && o_s_axis_tready))
        else $error("command commit out of step with input transfer");
`endif

endmodule

### tb/middle_insert_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// middle_insert_queue_unit_tb : command and result checks for the queue unit
// Sends push, middle insert and pop commands with random gaps on both streams.
// A queue image predicts each result, and every result transfer is checked
// in order against it.
// ----------------------------------------------------------------------------
module middle_insert_queue_unit_tb;

    localparam int unsigned QUEUE_DEPTH    = miq_pkg::CAPACITY_DEF;
    // unused code, decodes as a pop
    localparam logic [miq_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int unsigned STALL_PERCENT  = 25;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned RANDOM_ITEMS   = 100;
    localparam int unsigned SEGMENT_ITEMS  = 50;
    localparam int unsigned PRESSURE_ITEMS = 24;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [31:0]         i_s_axis_tdata  = '0;   // [31:0] value
    logic [1:0]          i_s_axis_tuser  = '0;   // [1:0] cmd
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [47:0]         o_m_axis_tdata;         // [31:0] popped_value, [40:32] entry_count
    logic [2:0]          o_m_axis_tuser;         // [0] popped_valid, [2:1] status

    // stream behaviour switches, flipped by the tests
    logic                sender_gaps     = 1'b1;
    logic                receiver_gaps   = 1'b1;
    logic                hold_request    = 1'b0;

    // queue image (head at index 0) and results still owed by the block
    logic signed [miq_pkg::VALUE_W-1:0] queue_image[$];
    miq_pkg::t_result                   owed_results[$];
    int unsigned                        error_count = 0;

    middle_insert_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Applies one command to the queue image and returns the result it owes.
    function automatic miq_pkg::t_result apply_command(
        input logic [miq_pkg::CMD_W-1:0]          cmd,
        input logic signed [miq_pkg::VALUE_W-1:0] value
    );
        miq_pkg::t_result res;
        int unsigned      slot;
        res        = '0;
        res.status = miq_pkg::ST_OK;
        case (cmd)
            miq_pkg::CMD_PUSH, miq_pkg::CMD_MIDDLE: begin
                if (queue_image.size() >= QUEUE_DEPTH) begin
                    res.status = miq_pkg::ST_FULL;   // dropped, queue untouched
                end else if (cmd == miq_pkg::CMD_PUSH) begin
                    queue_image.insert(queue_image.size(), value);
                end else begin
                    // (count+1)/2 entries stay ahead of the new one
                    slot = (queue_image.size() + 1) / 2;
                    queue_image.insert(slot, value);
                end
            end
            default: begin
                if (queue_image.size() == 0) begin
                    res.status = miq_pkg::ST_EMPTY;
                end else begin
                    res.popped_value = queue_image[0];
                    res.popped_valid = 1'b1;
                    queue_image.delete(0);
                end
            end
        endcase
        res.entry_count = miq_pkg::COUNT_W'(queue_image.size());
        return res;
    endfunction

    // Mostly full-range random values, with the sign, zero and all-ones corners mixed in.
    function automatic logic signed [miq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [miq_pkg::CMD_W-1:0] pick_pop();
        return ($urandom_range(7) == 0) ? CMD_SPARE : miq_pkg::CMD_POP;
    endfunction

    function automatic logic [miq_pkg::CMD_W-1:0] pick_insert();
        return $urandom_range(1) ? miq_pkg::CMD_MIDDLE : miq_pkg::CMD_PUSH;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] check error: %s", $realtime, msg);
        end
    endtask

    // One command transfer; valid stays high into the next call unless a gap falls.
    task automatic send_command(input logic [miq_pkg::CMD_W-1:0] cmd,
                                input logic signed [miq_pkg::VALUE_W-1:0] value);
        @(negedge i_clk);
        while (sender_gaps && $urandom_range(99) < STALL_PERCENT) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = value;
        i_s_axis_tuser  = cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        owed_results.insert(owed_results.size(), apply_command(cmd, value));
    endtask

    // Result side: random stalls, or one long hold-off when a test asks for it.
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_m_axis_tready = !(receiver_gaps && $urandom_range(99) < STALL_PERCENT);
            end
        end
    end

    // Every result transfer is matched against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        miq_pkg::t_result seen;
        miq_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.popped_value = o_m_axis_tdata[31:0];
            seen.entry_count  = o_m_axis_tdata[40:32];
            seen.popped_valid = o_m_axis_tuser[0];
            seen.status       = o_m_axis_tuser[2:1];
            if (owed_results.size() == 0) begin
                note_failure($sformatf("result transfer with none owed: value %h count %0d",
                                       seen.popped_value, seen.entry_count));
            end else begin
                want = owed_results[0];
                owed_results.delete(0);
                if (seen.popped_value !== want.popped_value) begin
                    note_failure($sformatf("popped_value exp %h got %h",
                                           want.popped_value, seen.popped_value));
                end
                if (seen.popped_valid !== want.popped_valid) begin
                    note_failure($sformatf("popped_valid exp %b got %b",
                                           want.popped_valid, seen.popped_valid));
                end
                if (seen.status !== want.status) begin
                    note_failure($sformatf("status exp %0d got %0d",
                                           want.status, seen.status));
                end
                if (seen.entry_count !== want.entry_count) begin
                    note_failure($sformatf("entry_count exp %0d got %0d",
                                           want.entry_count, seen.entry_count));
                end
            end
        end
    end

    // Ends the run once no transfer has happened on either stream for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Pops on an empty queue, both with the pop code and the spare code.
    task automatic test_empty_queue();
        send_command(miq_pkg::CMD_POP, pick_value());
        send_command(CMD_SPARE, pick_value());
    endtask

    // Sign and bit-pattern corners through every insert position, then drained.
    task automatic test_field_extremes();
        send_command(miq_pkg::CMD_PUSH,   32'sh7FFF_FFFF);
        send_command(miq_pkg::CMD_PUSH,   32'sh8000_0000);
        send_command(miq_pkg::CMD_MIDDLE, 32'sh0000_0000);   // lands between the two
        send_command(miq_pkg::CMD_MIDDLE, 32'shFFFF_FFFF);   // odd count, rounds up
        send_command(miq_pkg::CMD_PUSH,   32'shAAAA_AAAA);
        send_command(miq_pkg::CMD_MIDDLE, 32'sh5555_5555);
        send_command(miq_pkg::CMD_POP,    32'sh0000_0000);
        send_command(CMD_SPARE,           32'shFFFF_FFFF);
        repeat (4) send_command(miq_pkg::CMD_POP, pick_value());
        send_command(CMD_SPARE, pick_value());                // queue now empty
        send_command(miq_pkg::CMD_POP, pick_value());
    endtask

    // Results held back long enough that the result buffer fills and input stalls.
    task automatic test_back_pressure();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (PRESSURE_ITEMS) begin
            send_command(($urandom_range(3) == 0) ? pick_pop() : pick_insert(), pick_value());
        end
        sender_gaps = 1'b1;
    endtask

    // Fill to capacity, try both inserts on a full queue, then drain past empty.
    task automatic test_full_queue();
        while (queue_image.size() < QUEUE_DEPTH) begin
            send_command(pick_insert(), pick_value());
        end
        send_command(miq_pkg::CMD_PUSH,   32'sh7FFF_FFFF);
        send_command(miq_pkg::CMD_MIDDLE, 32'sh8000_0000);
        send_command(miq_pkg::CMD_POP,    pick_value());
        send_command(miq_pkg::CMD_MIDDLE, pick_value());     // refills the last slot
        send_command(miq_pkg::CMD_MIDDLE, pick_value());
        while (queue_image.size() > 0) begin
            send_command(pick_pop(), pick_value());
        end
        send_command(miq_pkg::CMD_POP, pick_value());
    endtask

    // Segments drifting towards full, towards empty or level; one with no gaps.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned segment;
        int unsigned insert_share;
        logic [miq_pkg::CMD_W-1:0] cmd;
        segment = 0;
        while (segment * SEGMENT_ITEMS < n_items) begin
            case ($urandom_range(2))
                0:       insert_share = 75;
                1:       insert_share = 25;
                default: insert_share = 50;
            endcase
            sender_gaps   = (segment != 1);
            receiver_gaps = (segment != 1);
            repeat (SEGMENT_ITEMS) begin
                cmd = ($urandom_range(99) < insert_share) ? pick_insert() : pick_pop();
                send_command(cmd, pick_value());
            end
            segment++;
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    initial begin : run_sequence
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_field_extremes();
        test_back_pressure();
        test_full_queue();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        // a stray result would turn up during this settle wait
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && owed_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
